// File: sv/lnpt_pkg.sv
// Shared types and codes for the local network prefix table.
// Holds the item kinds, result status codes, the stored entry layout and the
// request layout. Used by lnpt_match, the top level and the checker; depends on nothing.
package lnpt_pkg;

  localparam int TABLE_ENTRIES_DEF = 64;

  typedef enum logic [1:0] {
    KIND_CLASSIFY = 2'd0,
    KIND_INSERT   = 2'd1,
    KIND_REMOVE   = 2'd2,
    KIND_UNUSED   = 2'd3
  } kind_t;

  localparam logic [3:0] ST_NEITHER    = 4'd0;
  localparam logic [3:0] ST_A          = 4'd1;
  localparam logic [3:0] ST_B          = 4'd2;
  localparam logic [3:0] ST_BOTH       = 4'd3;
  localparam logic [3:0] ST_FAMILY_ERR = 4'd4;
  localparam logic [3:0] ST_ADDED      = 4'd5;
  localparam logic [3:0] ST_DUPLICATE  = 4'd6;
  localparam logic [3:0] ST_FULL       = 4'd7;
  localparam logic [3:0] ST_REMOVED    = 4'd8;
  localparam logic [3:0] ST_NOT_FOUND  = 4'd9;

  // IPv4 networks live in the upper 32 bits of the high word.
  localparam logic [63:0] V4_HI_MASK = 64'hFFFF_FFFF_0000_0000;

  typedef struct packed {
    logic        valid;
    logic [7:0]  device;
    logic        is_ipv6;
    logic [63:0] net_hi;
    logic [63:0] net_lo;
    logic [7:0]  prefix_len;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  device;
    logic        a_is_ipv6;
    logic [63:0] a_hi;
    logic [63:0] a_lo;
    logic [7:0]  prefix_len;
    logic        b_is_ipv6;
    logic [63:0] b_hi;
    logic [63:0] b_lo;
  } req_t;

  typedef struct packed {
    logic ident;
    logic hit_a;
    logic hit_b;
    logic free;
  } match_t;

endpackage

// File: sv/lnpt_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Width and depth are parameters; no dependencies.
module lnpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/lnpt_match.sv
// Compares one stored entry against the current request.
// Gives identity, locality of A and B, and whether the slot is free.
// Depends on lnpt_pkg.
module lnpt_match (
  input  lnpt_pkg::entry_t entry,
  input  lnpt_pkg::req_t   req,
  output lnpt_pkg::match_t result
);
  import lnpt_pkg::*;

  localparam logic [63:0] ONES = '1;

  logic [7:0]  len_v6;
  logic [7:0]  len_v4;
  logic [6:0]  n_hi;
  logic [6:0]  n_lo;
  logic [63:0] mhi;
  logic [63:0] mlo;
  logic        sel;

  always_comb begin
    len_v6 = (entry.prefix_len > 8'd128) ? 8'd128 : entry.prefix_len;
    len_v4 = (entry.prefix_len > 8'd32) ? 8'd32 : entry.prefix_len;
    if (entry.is_ipv6) begin
      n_hi = (len_v6 > 8'd64) ? 7'd64 : len_v6[6:0];
      n_lo = (len_v6 > 8'd64) ? 7'(len_v6 - 8'd64) : 7'd0;
    end else begin
      n_hi = len_v4[6:0];
      n_lo = 7'd0;
    end
    // Top n bits set; a shift of 64 leaves all ones.
    mhi = ~(ONES >> n_hi);
    mlo = ~(ONES >> n_lo);

    sel = entry.valid && (entry.device == req.device) &&
          (entry.is_ipv6 == req.a_is_ipv6);

    result.hit_a = sel && (((req.a_hi ^ entry.net_hi) & mhi) == 64'd0) &&
                   (((req.a_lo ^ entry.net_lo) & mlo) == 64'd0);
    result.hit_b = sel && (((req.b_hi ^ entry.net_hi) & mhi) == 64'd0) &&
                   (((req.b_lo ^ entry.net_lo) & mlo) == 64'd0);
    result.ident = sel && (entry.prefix_len == req.prefix_len) &&
                   (entry.net_hi == req.a_hi) && (entry.net_lo == req.a_lo);
    result.free  = !entry.valid;
  end

endmodule

// File: sv/local_network_prefix_table_core.sv
// Local network prefix table: top level with the scan sequencer.
// Depends on lnpt_pkg, lnpt_ram and lnpt_match.
//
// Input channel: in_valid/in_stall with kind, device, addresses A and B and
// a prefix length. Output channel: out_valid/out_stall with one status beat
// per input beat, in order.
//
// Every insert, remove or classify beat scans the whole table, one entry per
// cycle through the single read port of the entry RAM. A classify beat with
// differing families, or an unused kind, skips the scan and goes straight to
// the finish state, where the result is registered.
//
// After reset the block clears the entry RAM, one entry per cycle, and holds
// in_stall high meanwhile.
// The result sits in an output register; a new beat is accepted while it
// waits. If the receiver still stalls when the next result is ready, the
// block waits and keeps in_stall high.
module local_network_prefix_table_core #(
  parameter int TABLE_ENTRIES = lnpt_pkg::TABLE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [7:0]  device,
  input  logic        a_is_ipv6,
  input  logic [63:0] a_hi,
  input  logic [63:0] a_lo,
  input  logic [7:0]  prefix_len,
  input  logic        b_is_ipv6,
  input  logic [63:0] b_hi,
  input  logic [63:0] b_lo,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  status
);
  import lnpt_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(TABLE_ENTRIES - 1);

  typedef enum logic [3:0] {
    S_CLEAR  = 4'b0001,
    S_IDLE   = 4'b0010,
    S_SCAN   = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t           state;
  req_t             req;
  logic [IDX_W-1:0] clr_idx;
  logic [IDX_W-1:0] rd_idx;
  logic             rd_active;
  logic             cmp_valid;
  logic             cmp_last;
  logic [IDX_W-1:0] cmp_idx;
  logic             found;
  logic [IDX_W-1:0] found_idx;
  logic             free_f;
  logic [IDX_W-1:0] free_idx;
  logic             hit_a;
  logic             hit_b;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  entry_t           ram_rdata;
  match_t           m;
  logic             in_acc;
  logic             out_free;
  logic             short_item;
  logic [3:0]       status_next;
  req_t             req_next;

  lnpt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(rd_idx),
    .rdata(ram_rdata)
  );

  lnpt_match u_match (
    .entry (ram_rdata),
    .req   (req),
    .result(m)
  );

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    req_next.kind       = kind;
    req_next.device     = device;
    req_next.a_is_ipv6  = a_is_ipv6;
    req_next.a_hi       = a_hi;
    req_next.a_lo       = a_lo;
    req_next.prefix_len = prefix_len;
    req_next.b_is_ipv6  = b_is_ipv6;
    req_next.b_hi       = b_hi;
    req_next.b_lo       = b_lo;
    // Table updates store and compare IPv4 networks with the low bits zeroed.
    if ((kind == KIND_INSERT || kind == KIND_REMOVE) && !a_is_ipv6) begin
      req_next.a_hi = a_hi & V4_HI_MASK;
      req_next.a_lo = 64'd0;
    end
    short_item = (kind == KIND_UNUSED) ||
                 (kind == KIND_CLASSIFY && a_is_ipv6 != b_is_ipv6);
  end

  always_comb begin
    status_next = ST_NEITHER;
    case (req.kind)
      KIND_CLASSIFY: begin
        if (req.a_is_ipv6 != req.b_is_ipv6) status_next = ST_FAMILY_ERR;
        else if (hit_a && hit_b)            status_next = ST_BOTH;
        else if (hit_a)                     status_next = ST_A;
        else if (hit_b)                     status_next = ST_B;
        else                                status_next = ST_NEITHER;
      end
      KIND_INSERT: begin
        if (found)        status_next = ST_DUPLICATE;
        else if (!free_f) status_next = ST_FULL;
        else              status_next = ST_ADDED;
      end
      KIND_REMOVE: begin
        status_next = found ? ST_REMOVED : ST_NOT_FOUND;
      end
      default: status_next = ST_NEITHER;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_idx;
    ram_wdata = '0;
    if (state == S_CLEAR) begin
      ram_we = 1'b1;
    end else if (state == S_FINISH && out_free) begin
      if (req.kind == KIND_INSERT && !found && free_f) begin
        ram_we               = 1'b1;
        ram_waddr            = free_idx;
        ram_wdata.valid      = 1'b1;
        ram_wdata.device     = req.device;
        ram_wdata.is_ipv6    = req.a_is_ipv6;
        ram_wdata.net_hi     = req.a_hi;
        ram_wdata.net_lo     = req.a_lo;
        ram_wdata.prefix_len = req.prefix_len;
      end else if (req.kind == KIND_REMOVE && found) begin
        // The other fields of an invalid entry are never looked at.
        ram_we    = 1'b1;
        ram_waddr = found_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      rd_idx    <= '0;
      rd_active <= 1'b0;
      cmp_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            req       <= req_next;
            found     <= 1'b0;
            free_f    <= 1'b0;
            hit_a     <= 1'b0;
            hit_b     <= 1'b0;
            rd_idx    <= '0;
            cmp_valid <= 1'b0;
            rd_active <= !short_item;
            state     <= short_item ? S_FINISH : S_SCAN;
          end
        end
        S_SCAN: begin
          // The read pipeline has drained by the time the last entry is compared.
          cmp_valid <= rd_active;
          cmp_idx   <= rd_idx;
          cmp_last  <= (rd_idx == LAST);
          if (rd_active) begin
            if (rd_idx == LAST) begin
              rd_active <= 1'b0;
            end else begin
              rd_idx <= rd_idx + 1'b1;
            end
          end
          if (cmp_valid) begin
            if (m.ident && !found) begin
              found     <= 1'b1;
              found_idx <= cmp_idx;
            end
            if (m.free && !free_f) begin
              free_f   <= 1'b1;
              free_idx <= cmp_idx;
            end
            hit_a <= hit_a || m.hit_a;
            hit_b <= hit_b || m.hit_b;
            if (cmp_last) begin
              state <= S_FINISH;
            end
          end
        end
        S_FINISH: begin
          if (out_free) begin
            status <= status_next;
            state  <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

endmodule

// File: sv/lnpt_checker.sv
// Port-level checks for the local network prefix table, and the bind that
// attaches them to the top level. Depends on lnpt_pkg.
module lnpt_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [3:0] status
);
  import lnpt_pkg::*;

  // Reset empties the output register and starts the clearing pass.
  a_reset_state: assert property (@(posedge clk)
    rst |=> (!out_valid && in_stall))
    else $error("reset did not clear output or hold input stalled");

  // One beat is processed at a time, so an accepted beat stalls the input.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted twice in a row");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status <= ST_NOT_FOUND))
    else $error("status code out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(status)))
    else $error("stalled result changed");

endmodule

bind local_network_prefix_table_core lnpt_checker u_lnpt_checker (.*);
